// ===== rtl/rsmp_pkg.sv =====
// rsmp_pkg: shared constants, sequencer state type and control struct for the
// stereo linear resampler. No dependencies.

package rsmp_pkg;

  localparam int RSMP_FRAC_BITS = 32;
  localparam int RSMP_POS_W     = 37;
  localparam int RSMP_SMP_W     = 16;
  localparam int RSMP_MAX_RUN   = 64;
  localparam int RSMP_CNT_W     = $clog2(RSMP_MAX_RUN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE_L,
    ST_ISSUE_R,
    ST_DRAIN_L,
    ST_DRAIN_R,
    ST_EMIT,
    ST_FINISH
  } rsmp_state_t;

  // sequencer -> datapath controls
  typedef struct packed {
    logic sel_right;      // feed right channel into the lerp unit
    logic cap_left;       // lerp result is the left sample
    logic cap_right;      // lerp result is the right sample
    logic hold_from_in;   // priming: held frame <- input
    logic hold_from_cur;  // advance: held frame <- current frame
    logic out_valid;
    logic last;
  } rsmp_ctl_t;

endpackage

// ===== rtl/rsmp_if.sv =====
// rsmp_in_if / rsmp_out_if: valid/ready stream interfaces for input frames
// and interpolated result frames. Depends on rsmp_pkg.

interface rsmp_in_if
  import rsmp_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [RSMP_SMP_W-1:0] in_left;
  logic signed [RSMP_SMP_W-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface rsmp_out_if
  import rsmp_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [RSMP_SMP_W-1:0] out_left;
  logic signed [RSMP_SMP_W-1:0] out_right;
  logic                         last_of_run;

  modport source (output valid, output out_left, output out_right, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_left, input out_right, input last_of_run,
                  output ready);
endinterface

// ===== rtl/stereo_linear_resampler_unit.sv =====
// stereo_linear_resampler_unit: linear-interpolation sample rate converter.
// The priming frame is only held. Other frames are accepted, checked, then give
// up to 64 outputs via issue, drain and emit (one shared 16x32 multiplier, two
// channels in turn), then finish; a new frame is taken only once back in idle.
// Reset (rst_n, synchronous, active low): phase_step = 1.0, position 0, unprimed.

module stereo_linear_resampler_unit
  import rsmp_pkg::*;
#(
  parameter int FRAC_BITS = RSMP_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rsmp_in_if.sink               in_req,
  rsmp_out_if.source            out_rsp,
  input  logic                  cfg_we,
  input  logic [RSMP_POS_W-1:0] cfg_wdata
);

  localparam logic [RSMP_POS_W-1:0] STEP_RST = RSMP_POS_W'(1) << FRAC_BITS;

  // rate register: input rate / output rate, FRAC_BITS fraction bits
  logic [RSMP_POS_W-1:0] phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RST;
    end else if (cfg_we) begin
      phase_step_r <= cfg_wdata;
    end
  end

  // held (previous) frame and current request frame
  logic signed [RSMP_SMP_W-1:0] held_l_r, held_r_r;
  logic signed [RSMP_SMP_W-1:0] cur_l_r, cur_r_r;
  logic signed [RSMP_SMP_W-1:0] out_l_r, out_r_r;
  logic                         in_ready;
  logic [FRAC_BITS-1:0]         frac;
  rsmp_ctl_t                    ctl;
  logic signed [RSMP_SMP_W-1:0] lerp_prev, lerp_cur, lerp_res;
  logic                         in_fire;

  assign in_fire = in_req.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_l_r <= '0;
      held_r_r <= '0;
    end else if (ctl.hold_from_in) begin
      held_l_r <= in_req.in_left;
      held_r_r <= in_req.in_right;
    end else if (ctl.hold_from_cur) begin
      held_l_r <= cur_l_r;
      held_r_r <= cur_r_r;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_l_r <= in_req.in_left;
      cur_r_r <= in_req.in_right;
    end
    if (ctl.cap_left)  out_l_r <= lerp_res;
    if (ctl.cap_right) out_r_r <= lerp_res;
  end

  rsmp_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .out_ready  (out_rsp.ready),
    .phase_step (phase_step_r),
    .in_ready   (in_ready),
    .frac       (frac),
    .ctl        (ctl)
  );

  // one lerp unit, left then right channel on consecutive cycles
  assign lerp_prev = ctl.sel_right ? held_r_r : held_l_r;
  assign lerp_cur  = ctl.sel_right ? cur_r_r  : cur_l_r;

  rsmp_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk    (clk),
    .prev   (lerp_prev),
    .cur    (lerp_cur),
    .frac   (frac),
    .result (lerp_res)
  );

  assign in_req.ready        = in_ready;
  assign out_rsp.valid       = ctl.out_valid;
  assign out_rsp.out_left    = out_l_r;
  assign out_rsp.out_right   = out_r_r;
  assign out_rsp.last_of_run = ctl.last;

  // busy while a result is pending
  a_no_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // a non-final result keeps the block busy
  a_busy_after_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.ready && !ctl.last) |=> !in_ready)
    else $error("block went idle before the final result");

  // final result returns to idle after the finish cycle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.ready && ctl.last) |-> ##2 in_ready)
    else $error("block not idle after final result");

  // an accepted non-priming request always leaves the block busy in the next cycle
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !ctl.hold_from_in) |=> !in_ready)
    else $error("block ready right after a paired request");

endmodule

// ===== rtl/rsmp_lerp.sv =====
// rsmp_lerp: shared two-stage interpolation unit, prev + trunc0((cur-prev)*frac).
// One channel per cycle in; the product, then the result, is registered. Depends on rsmp_pkg.

module rsmp_lerp
  import rsmp_pkg::*;
#(
  parameter int FRAC_BITS = RSMP_FRAC_BITS
) (
  input  logic                         clk,
  input  logic signed [RSMP_SMP_W-1:0] prev,
  input  logic signed [RSMP_SMP_W-1:0] cur,
  input  logic        [FRAC_BITS-1:0]  frac,
  output logic signed [RSMP_SMP_W-1:0] result
);

  logic signed [RSMP_SMP_W:0]            diff;
  logic        [RSMP_SMP_W-1:0]          mag;
  logic        [RSMP_SMP_W+FRAC_BITS-1:0] prod_r;
  logic                                  neg_r;
  logic signed [RSMP_SMP_W-1:0]          prev_r;
  logic        [RSMP_SMP_W-1:0]          part;
  logic signed [RSMP_SMP_W:0]            term;
  logic signed [RSMP_SMP_W:0]            sum;
  logic signed [RSMP_SMP_W-1:0]          result_r;

  // |diff| is at most 2^16-1, so 16 bits hold it
  always_comb begin
    diff = (RSMP_SMP_W+1)'(cur) - (RSMP_SMP_W+1)'(prev);
    mag  = diff[RSMP_SMP_W] ? RSMP_SMP_W'(-diff) : diff[RSMP_SMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= (RSMP_SMP_W+FRAC_BITS)'(mag) * (RSMP_SMP_W+FRAC_BITS)'(frac);
    neg_r  <= diff[RSMP_SMP_W];
    prev_r <= prev;
  end

  // truncation toward zero: shift the magnitude, then restore the sign
  always_comb begin
    part = prod_r[FRAC_BITS +: RSMP_SMP_W];
    term = neg_r ? -$signed({1'b0, part}) : $signed({1'b0, part});
    sum  = (RSMP_SMP_W+1)'(prev_r) + term;
  end

  always_ff @(posedge clk) begin
    result_r <= sum[RSMP_SMP_W-1:0];
  end

  assign result = result_r;

endmodule

// ===== rtl/rsmp_seq.sv =====
// rsmp_seq: sequencer for the resampler; owns the phase accumulator, run
// counter and primed flag, and steps the shared lerp unit. Depends on rsmp_pkg.

module rsmp_seq
  import rsmp_pkg::*;
#(
  parameter int FRAC_BITS = RSMP_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_ready,
  input  logic [RSMP_POS_W-1:0] phase_step,
  output logic                  in_ready,
  output logic [FRAC_BITS-1:0]  frac,
  output rsmp_ctl_t             ctl
);

  localparam logic [RSMP_POS_W-1:0] ONE_POS  = RSMP_POS_W'(1) << FRAC_BITS;
  localparam logic [RSMP_CNT_W-1:0] LAST_CNT = RSMP_CNT_W'(RSMP_MAX_RUN - 1);

  rsmp_state_t           state_r, state_nxt;
  logic [RSMP_POS_W-1:0] pos_r;
  logic [RSMP_CNT_W-1:0] cnt_r;
  logic                  last_r;
  logic                  primed_r;

  logic                  pos_below;
  logic [RSMP_POS_W:0]   sum;
  logic [RSMP_POS_W-1:0] pos_sat;
  logic                  sat_below;
  logic                  in_fire;

  always_comb begin
    pos_below = ~|pos_r[RSMP_POS_W-1:FRAC_BITS];
    sum       = {1'b0, pos_r} + {1'b0, phase_step};
    pos_sat   = sum[RSMP_POS_W] ? '1 : sum[RSMP_POS_W-1:0];
    sat_below = ~|pos_sat[RSMP_POS_W-1:FRAC_BITS];
    in_fire   = in_valid && (state_r == ST_IDLE);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire && primed_r) state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = pos_below ? ST_ISSUE_L : ST_FINISH;
      ST_ISSUE_L: state_nxt = ST_ISSUE_R;
      ST_ISSUE_R: state_nxt = ST_DRAIN_L;
      ST_DRAIN_L: state_nxt = ST_DRAIN_R;
      ST_DRAIN_R: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ready) state_nxt = last_r ? ST_FINISH : ST_ISSUE_L;
      end
      ST_FINISH:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl               = '0;
    ctl.sel_right     = (state_r == ST_ISSUE_R);
    ctl.cap_left      = (state_r == ST_DRAIN_L);
    ctl.cap_right     = (state_r == ST_DRAIN_R);
    ctl.hold_from_in  = in_fire && !primed_r;
    ctl.hold_from_cur = (state_r == ST_FINISH);
    ctl.out_valid     = (state_r == ST_EMIT);
    ctl.last          = last_r;
    in_ready          = (state_r == ST_IDLE);
    frac              = pos_r[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= '0;
      cnt_r    <= '0;
      last_r   <= 1'b0;
      primed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        primed_r <= 1'b1;
        cnt_r    <= '0;
      end
      if (state_r == ST_DRAIN_R) begin
        pos_r  <= pos_sat;
        last_r <= !sat_below || (cnt_r == LAST_CNT);
        cnt_r  <= cnt_r + 1'b1;
      end
      if (state_r == ST_FINISH) begin
        pos_r <= pos_below ? '0 : pos_r - ONE_POS;
      end
    end
  end

endmodule
